[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  `ASSERT_ALWAYS(name, (ante) |-> (cons), msg)

// Next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  `ASSERT_ALWAYS(name, (ante) |=> (cons), msg)

`endif

[hw/rtl/bec_pkg.sv]
// Types, constants and helper functions for the backlight effect controller
package bec_pkg;

  localparam int unsigned FADE_SPEED = 8;
  localparam int unsigned FADE_TERM  = 255 * FADE_SPEED;

  localparam logic [7:0] PWM_FULL    = 8'd255;
  localparam logic [3:0] LEVEL_TOP   = 4'd12;
  localparam logic [7:0] BRIGHT_MIN  = 8'd30;
  localparam logic [7:0] BRIGHT_STEP = 8'd25;
  localparam logic [8:0] HOLD_TICKS  = 9'd500;
  localparam logic [3:0] UP_ENTRY    = 4'd3;
  localparam logic [3:0] DOWN_ENTRY  = 4'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    ACT_TICK,
    ACT_KEY,
    ACT_NEXT,
    ACT_BRIGHTER,
    ACT_DIMMER,
    ACT_ON,
    ACT_OFF,
    ACT_START
  } action_e;

  typedef enum logic [2:0] {
    MODE_OFF,
    MODE_FADE,
    MODE_ON,
    MODE_UP,
    MODE_DOWN
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MODE,
    CFG_START_BRIGHT
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  bright;
    logic [11:0] fade_count;
    logic [1:0]  fade_phase;
    logic [3:0]  level;
    logic [7:0]  life;
    logic [8:0]  hold;
    logic [7:0]  duty;
    logic        lights_off;
    logic        started;
  } state_t;

  // 255 * level / 12, truncated
  function automatic logic [7:0] life_of_level(logic [3:0] lvl);
    logic [7:0] r;
    case (lvl)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd21;
      4'd2:    r = 8'd42;
      4'd3:    r = 8'd63;
      4'd4:    r = 8'd85;
      4'd5:    r = 8'd106;
      4'd6:    r = 8'd127;
      4'd7:    r = 8'd148;
      4'd8:    r = 8'd170;
      4'd9:    r = 8'd191;
      4'd10:   r = 8'd212;
      4'd11:   r = 8'd233;
      default: r = PWM_FULL;
    endcase
    return r;
  endfunction

  // 12 - (255 - life) / 21; the quotient via reciprocal 3121 / 2^16, exact for 8 bits
  function automatic logic [3:0] level_of_life(logic [7:0] life);
    logic [7:0]  d;
    logic [19:0] p;
    d = PWM_FULL - life;
    p = 20'(d) * 20'd3121;
    return LEVEL_TOP - p[19:16];
  endfunction

  // v * b / 255 using x / 255 = (x + (x >> 8) + 1) >> 8
  function automatic logic [7:0] scale(logic [7:0] v, logic [7:0] b);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(v) * 16'(b);
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

[hw/rtl/bec_intf.sv]
// Handshake channel interfaces for the backlight effect controller
interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       asleep;

  modport source (output valid, action, asleep, input ready);
  modport sink   (input valid, action, asleep, output ready);
endinterface

interface bec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_duty;
  logic [2:0] effect_mode;
  logic [7:0] brightness_limit;
  logic [3:0] key_level;

  modport source (output valid, pwm_duty, effect_mode, brightness_limit, key_level,
                  input ready);
  modport sink   (input valid, pwm_duty, effect_mode, brightness_limit, key_level,
                  output ready);
endinterface

interface bec_cfg_if import bec_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

[hw/rtl/bec_update.sv]
// Next-state logic: applies one item to the effect state
module bec_update import bec_pkg::*; (
  input  state_t     state_i,
  input  logic [2:0] action_i,
  input  logic       asleep_i,
  input  logic [2:0] cfg_mode_i,
  input  logic [7:0] cfg_bright_i,
  output state_t     state_o
);

  function automatic state_t enter_mode(state_t s_in);
    state_t s;
    s = s_in;
    case (s.mode)
      MODE_OFF:  s.duty = 8'd0;
      MODE_FADE: begin
        s.fade_count = '0;
        s.fade_phase = 2'd0;
      end
      MODE_ON:   s.duty = s.bright;
      MODE_UP:   begin
        s.level = UP_ENTRY;
        s.life  = life_of_level(UP_ENTRY);
      end
      MODE_DOWN: begin
        s.level = DOWN_ENTRY;
        s.life  = life_of_level(DOWN_ENTRY);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic state_t tick(state_t s_in);
    state_t      s;
    logic [12:0] c;
    logic [9:0]  cdiv;
    logic [7:0]  fsat;
    logic        up;
    logic        moving;
    s    = s_in;
    c    = {1'b0, s.fade_count};
    cdiv = 10'(c / FADE_SPEED);
    fsat = (cdiv > 10'(PWM_FULL)) ? PWM_FULL : cdiv[7:0];
    up   = (s.mode == MODE_DOWN);
    if (s.mode == MODE_FADE) begin
      if (s.fade_phase == 2'd0) begin
        s.duty = scale(fsat, s.bright);
      end else if (s.fade_phase == 2'd2) begin
        s.duty = scale(PWM_FULL - fsat, s.bright);
      end else begin
        c = c + 13'd1;
      end
      if (c >= 13'(FADE_TERM)) begin
        c            = '0;
        s.fade_phase = s.fade_phase + 2'd1;
      end
      c            = c + 13'd1;
      s.fade_count = c[11:0];
    end else if (s.mode == MODE_UP || s.mode == MODE_DOWN) begin
      moving = up ? (s.life != PWM_FULL) : (s.life != 8'd0);
      if (s.hold != 9'd0) begin
        s.hold = s.hold - 9'd1;
      end else if (moving) begin
        c = c + 13'd1;
        if (c >= 13'(FADE_SPEED)) begin
          c       = '0;
          s.life  = up ? s.life + 8'd1 : s.life - 8'd1;
          s.level = level_of_life(s.life);
        end
        s.fade_count = c[11:0];
      end else begin
        s.level      = up ? LEVEL_TOP : 4'd0;
        s.fade_count = '0;
      end
      s.duty = scale(s.life, s.bright);
    end else begin
      s.fade_count = '0;
      s.fade_phase = 2'd3;
    end
    return s;
  endfunction

  logic [8:0] bright_up;
  assign bright_up = {1'b0, state_i.bright} + {1'b0, BRIGHT_STEP};

  always_comb begin
    state_o = state_i;
    case (action_i)
      ACT_TICK: begin
        if (state_i.started && !asleep_i && !state_i.lights_off) state_o = tick(state_i);
      end
      ACT_KEY: begin
        if (!asleep_i && !state_i.lights_off) begin
          if (state_i.mode == MODE_UP) begin
            state_o.hold = HOLD_TICKS;
            if (state_i.level < LEVEL_TOP) begin
              state_o.level = state_i.level + 4'd1;
              state_o.life  = life_of_level(state_i.level + 4'd1);
            end
          end else if (state_i.mode == MODE_DOWN) begin
            state_o.hold = HOLD_TICKS;
            if (state_i.level != 4'd0) begin
              state_o.level = state_i.level - 4'd1;
              state_o.life  = life_of_level(state_i.level - 4'd1);
            end
          end
        end
      end
      ACT_NEXT: begin
        if (!asleep_i) begin
          state_o.mode = (state_i.mode == MODE_DOWN) ? MODE_OFF : state_i.mode + 3'd1;
          state_o      = enter_mode(state_o);
        end
      end
      ACT_BRIGHTER: begin
        if (state_i.bright != PWM_FULL) begin
          state_o.bright = (bright_up > 9'(PWM_FULL)) ? PWM_FULL : bright_up[7:0];
          if (state_i.mode == MODE_ON) state_o = enter_mode(state_o);
        end
      end
      ACT_DIMMER: begin
        if (state_i.bright != BRIGHT_MIN) begin
          state_o.bright = (state_i.bright < BRIGHT_MIN + BRIGHT_STEP) ? BRIGHT_MIN
                                                                      : state_i.bright - BRIGHT_STEP;
          if (state_i.mode == MODE_ON) state_o = enter_mode(state_o);
        end
      end
      ACT_ON: begin
        state_o.lights_off = 1'b0;
        state_o            = enter_mode(state_o);
      end
      ACT_OFF: begin
        state_o.lights_off = 1'b1;
        state_o.duty       = 8'd0;
      end
      ACT_START: begin
        state_o.mode    = (cfg_mode_i <= MODE_DOWN) ? cfg_mode_i : MODE_OFF;
        state_o.bright  = (cfg_bright_i < BRIGHT_MIN) ? BRIGHT_MIN : cfg_bright_i;
        state_o         = enter_mode(state_o);
        state_o.started = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/backlight_effect_controller.sv]
// Backlight effect controller top level: item register, effect state and result handshake
//
// Each accepted item is held in an input register, applied to the effect state by a
// single pass of next-state logic, and the updated state is the result register: the
// result is presented once the item moves from the input register into the result
// register, which waits while an earlier result is stalled. One item per cycle is
// sustained while results are taken; the input register refills in the same cycle that
// its item moves into the result register. While a result waits, a new item is taken
// only when the input register is empty or the waiting result is taken at the same
// edge. The rate is set by the single update path from input register to state register.
// Configuration writes are always ready and act on the next start action.
module backlight_effect_controller import bec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bec_in_if.sink    in_i,
  bec_out_if.source out_o,
  bec_cfg_if.sink   cfg_i
);

  localparam state_t StateReset = '{
    mode:       MODE_OFF,
    bright:     PWM_FULL,
    fade_count: '0,
    fade_phase: 2'd0,
    level:      4'd0,
    life:       8'd0,
    hold:       9'd0,
    duty:       8'd0,
    lights_off: 1'b0,
    started:    1'b0
  };

  logic       in_valid_q;
  logic [2:0] action_q;
  logic       asleep_q;
  logic       out_valid_q;
  logic [2:0] cfg_mode_q;
  logic [7:0] cfg_bright_q;
  state_t     state_q, state_d;
  logic       consume;
  logic       in_take;

  assign consume  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || consume;
  assign in_take  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  bec_update u_update (
    .state_i      (state_q),
    .action_i     (action_q),
    .asleep_i     (asleep_q),
    .cfg_mode_i   (cfg_mode_q),
    .cfg_bright_i (cfg_bright_q),
    .state_o      (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= in_i.action;
      asleep_q <= in_i.asleep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= MODE_OFF;
      cfg_bright_q <= PWM_FULL;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_MODE:   cfg_mode_q   <= cfg_i.wdata[2:0];
        CFG_START_BRIGHT: cfg_bright_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pwm_duty         = state_q.duty;
  assign out_o.effect_mode      = state_q.mode;
  assign out_o.brightness_limit = state_q.bright;
  assign out_o.key_level        = state_q.level;

endmodule

[hw/rtl/bec_checker.sv]
// Port-level checks for the backlight effect controller, bound to the top level
`include "assert_macros.svh"

module bec_checker import bec_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] pwm_duty_i,
  input logic [2:0] effect_mode_i,
  input logic [7:0] brightness_limit_i,
  input logic [3:0] key_level_i
);

  logic        stalled;
  logic [22:0] fields;
  logic        in_range;
  logic        mode_off;
  logic        mode_on;
  logic        on_duty_ok;

  assign stalled    = out_valid_i && !out_ready_i;
  assign fields     = {pwm_duty_i, effect_mode_i, brightness_limit_i, key_level_i};
  assign in_range   = effect_mode_i <= MODE_DOWN && key_level_i <= LEVEL_TOP
                      && brightness_limit_i >= BRIGHT_MIN;
  assign mode_off   = out_valid_i && effect_mode_i == MODE_OFF;
  assign mode_on    = out_valid_i && effect_mode_i == MODE_ON;
  assign on_duty_ok = pwm_duty_i == brightness_limit_i || pwm_duty_i == 8'd0;

  `ASSERT_NEXT(a_stall_hold, stalled, out_valid_i && $stable(fields), "result changed while stalled")
  `ASSERT_IMPLIES(a_ranges, out_valid_i, in_range, "result field out of range")
  `ASSERT_IMPLIES(a_off_dark, mode_off, pwm_duty_i == 8'd0, "duty not zero in off mode")
  `ASSERT_IMPLIES(a_on_limit, mode_on, on_duty_ok, "steady-on duty does not follow limit")

endmodule

bind backlight_effect_controller bec_checker u_bec_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .pwm_duty_i         (out_o.pwm_duty),
  .effect_mode_i      (out_o.effect_mode),
  .brightness_limit_i (out_o.brightness_limit),
  .key_level_i        (out_o.key_level)
);
